>>> sv/rcps_pkg.sv
package rcps_pkg;

    // fixed field widths
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned WIDTH_W  = 12;
    localparam int unsigned DBAND_W  = 10;
    localparam int unsigned TABLE_W  = 32;
    localparam int unsigned DELAY_W  = 4;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // entries held in the delay table register
    localparam int unsigned REG_ENTRIES = TABLE_W / DELAY_W;

    // default parameter values
    localparam int unsigned TABLE_ENTRIES_DEF = 8;
    localparam int unsigned DIST_SHIFT_DEF    = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TABLE   = 3'd5;

    // register reset values
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd100;
    localparam logic [WIDTH_W-1:0]  CENTER_WIDTH_RST  = 12'd1500;
    localparam logic [DBAND_W-1:0]  DEADBAND_RST      = 10'd50;
    localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RST     = 12'd1000;
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST     = 12'd2000;
    localparam logic [TABLE_W-1:0]  DELAY_TABLE_RST   = 32'h1223_3444;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // pin levels carried by one result
    typedef struct packed {
        logic enable_pin;
        logic direction_pin;
        logic step_pin;
        logic sampled;
    } t_result;

endpackage

>>> sv/rc_pulse_to_stepper_rate_core.sv
// RC pulse to stepper step generator. Each request is one millisecond tick
// carrying the measured RC pulse width (0 = no signal) and yields exactly one
// result holding the enable, direction and step pin levels after that tick,
// plus a flag telling whether the tick took a sample. Every sample_period
// ticks the width is clamped to min_width..max_width; inside the open band
// center_width +/- deadband the motor is disabled and stepping stops, else
// the motor is enabled, direction is set by the side of center and a step
// delay is picked from delay_table by |width - center| >> DIST_SHIFT. The
// step pin toggles, while stepping, whenever the ticks since the last toggle reach the delay.
// Throughput is one tick per clock when the result side is not stalled; a
// tick passes the input register and then the result register, and all tick
// processing happens in the single logic level between them. Configuration
// is always ready and takes effect on the next tick processed; write it only while idle.
module rc_pulse_to_stepper_rate_core
    import rcps_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned DIST_SHIFT    = DIST_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_enable_pin,
    output logic                 o_direction_pin,
    output logic                 o_step_pin,
    output logic                 o_sampled,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [WIDTH_W-1:0] IDX_LAST = WIDTH_W'(TABLE_ENTRIES - 1);
    // signed width for center +/- deadband
    localparam int unsigned SW = WIDTH_W + 2;

    // configuration registers
    logic [PERIOD_W-1:0] r_sample_period;
    logic [WIDTH_W-1:0]  r_center_width;
    logic [DBAND_W-1:0]  r_deadband;
    logic [WIDTH_W-1:0]  r_min_width;
    logic [WIDTH_W-1:0]  r_max_width;
    logic [TABLE_W-1:0]  r_delay_table;

    // input register
    logic               r_in_valid;
    logic [WIDTH_W-1:0] r_in_width;

    // tick state
    logic [TICK_W-1:0]  r_ticks_sample, n_ticks_sample;
    logic [TICK_W-1:0]  r_ticks_step, n_ticks_step;
    logic               r_stepping, n_stepping;
    logic [DELAY_W-1:0] r_step_delay, n_step_delay;
    logic               r_enable, n_enable;
    logic               r_direction, n_direction;
    logic               r_step_level, n_step_level;

    // result register
    logic    r_out_valid;
    t_result r_out;

    // handshake control
    logic w_in_acc;
    logic w_out_free;
    logic w_adv;

    // tick datapath
    logic [TICK_W-1:0]          w_sample_inc;
    logic [TICK_W-1:0]          w_step_inc;
    logic                       w_take;
    logic [WIDTH_W-1:0]         w_lo_clamp;
    logic [WIDTH_W-1:0]         w_clamped;
    logic signed [SW-1:0]       w_w_s;
    logic signed [SW-1:0]       w_band_lo;
    logic signed [SW-1:0]       w_band_hi;
    logic                       w_in_band;
    logic                       w_below;
    logic [WIDTH_W-1:0]         w_dist;
    logic [WIDTH_W-1:0]         w_idx_full;
    logic [IDX_W-1:0]           w_idx;
    logic [DELAY_W-1:0]         w_delay;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RST;
            r_center_width  <= CENTER_WIDTH_RST;
            r_deadband      <= DEADBAND_RST;
            r_min_width     <= MIN_WIDTH_RST;
            r_max_width     <= MAX_WIDTH_RST;
            r_delay_table   <= DELAY_TABLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[PERIOD_W-1:0];
                REG_CENTER_WIDTH:  r_center_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_DEADBAND:      r_deadband      <= i_cfg_data[DBAND_W-1:0];
                REG_MIN_WIDTH:     r_min_width     <= i_cfg_data[WIDTH_W-1:0];
                REG_MAX_WIDTH:     r_max_width     <= i_cfg_data[WIDTH_W-1:0];
                REG_DELAY_TABLE:   r_delay_table   <= i_cfg_data;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // sample and step counters saturate at all ones
    assign w_sample_inc = (r_ticks_sample == TICK_MAX) ? TICK_MAX : r_ticks_sample + 1'b1;
    assign w_take       = (w_sample_inc >= r_sample_period);

    // clamp; crossed limits resolve to max_width
    assign w_lo_clamp = (r_in_width < r_min_width) ? r_min_width : r_in_width;
    assign w_clamped  = (w_lo_clamp > r_max_width) ? r_max_width : w_lo_clamp;

    // open stop band, compared signed since center - deadband may go negative
    assign w_w_s     = SW'(signed'({2'b00, w_clamped}));
    assign w_band_lo = signed'(SW'(r_center_width)) - signed'(SW'(r_deadband));
    assign w_band_hi = signed'(SW'(r_center_width)) + signed'(SW'(r_deadband));
    assign w_in_band = (w_w_s > w_band_lo) && (w_w_s < w_band_hi);

    // distance from center and table index with saturation at last entry
    assign w_below    = (w_clamped < r_center_width);
    assign w_dist     = w_below ? (r_center_width - w_clamped) : (w_clamped - r_center_width);
    assign w_idx_full = w_dist >> DIST_SHIFT;
    assign w_idx      = (w_idx_full > IDX_LAST) ? IDX_W'(TABLE_ENTRIES - 1)
                                                : w_idx_full[IDX_W-1:0];

    // table lookup; entries past the register read as zero delay
    always_comb begin
        w_delay = '0;
        for (int k = 0; k < REG_ENTRIES; k++) begin
            if (32'(w_idx) == k) begin
                w_delay = r_delay_table[k*DELAY_W +: DELAY_W];
            end
        end
    end

    // next tick state
    always_comb begin
        n_ticks_sample = w_sample_inc;
        n_stepping     = r_stepping;
        n_step_delay   = r_step_delay;
        n_enable       = r_enable;
        n_direction    = r_direction;
        if (w_take) begin
            n_ticks_sample = '0;
            if (r_in_width == '0) begin
                // no signal: stop stepping, keep the rest
                n_stepping = 1'b0;
            end else if (w_in_band) begin
                // stop band: disable the motor
                n_enable   = 1'b1;
                n_stepping = 1'b0;
            end else begin
                n_enable     = 1'b0;
                n_stepping   = 1'b1;
                n_direction  = w_below;
                n_step_delay = w_delay;
            end
        end

        // step counter keeps running while idle
        w_step_inc   = (r_ticks_step == TICK_MAX) ? TICK_MAX : r_ticks_step + 1'b1;
        n_ticks_step = w_step_inc;
        n_step_level = r_step_level;
        if (n_stepping && (w_step_inc >= TICK_W'(n_step_delay))) begin
            n_ticks_step = '0;
            n_step_level = !r_step_level;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_width <= i_pulse_width;
        end
    end

    // tick state, committed as the tick moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_sample <= '0;
            r_ticks_step   <= '0;
            r_stepping     <= 1'b0;
            r_step_delay   <= '0;
            r_enable       <= 1'b0;
            r_direction    <= 1'b0;
            r_step_level   <= 1'b0;
        end else if (w_adv) begin
            r_ticks_sample <= n_ticks_sample;
            r_ticks_step   <= n_ticks_step;
            r_stepping     <= n_stepping;
            r_step_delay   <= n_step_delay;
            r_enable       <= n_enable;
            r_direction    <= n_direction;
            r_step_level   <= n_step_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.enable_pin    <= n_enable;
            r_out.direction_pin <= n_direction;
            r_out.step_pin      <= n_step_level;
            r_out.sampled       <= w_take;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_enable_pin    = r_out.enable_pin;
    assign o_direction_pin = r_out.direction_pin;
    assign o_step_pin      = r_out.step_pin;
    assign o_sampled       = r_out.sampled;

    // a disabled motor never steps
    a_enable_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enable |-> !r_stepping)
        else $error("motor disabled while stepping");

    // step level only moves on a committed tick that is stepping
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv || !n_stepping) |=> $stable(r_step_level))
        else $error("step level changed without stepping");

    // a sampled tick restarts the sample counter
    a_sample_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_take) |=> (r_ticks_sample == '0))
        else $error("sample counter not cleared");

    // a stall toward the source always means a tick is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing held");

endmodule

>>> bench/rc_pulse_to_stepper_rate_checker.sv
`timescale 1ns / 100ps

module rc_pulse_to_stepper_rate_checker
    import rcps_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned DIST_SHIFT    = DIST_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [WIDTH_W-1:0]   i_pulse_width,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_enable_pin,
    input  logic                 i_direction_pin,
    input  logic                 i_step_pin,
    input  logic                 i_sampled,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // shadow registers
    logic [PERIOD_W-1:0] period_r;
    logic [WIDTH_W-1:0]  center_r;
    logic [DBAND_W-1:0]  dband_r;
    logic [WIDTH_W-1:0]  minw_r;
    logic [WIDTH_W-1:0]  maxw_r;
    logic [TABLE_W-1:0]  delays_r;

    // shadow tick state
    logic [TICK_W-1:0]  since_sample;
    logic [TICK_W-1:0]  since_step;
    logic               stepping;
    logic [DELAY_W-1:0] step_wait;
    logic               enable_lvl;
    logic               dir_lvl;
    logic               step_lvl;

    t_result pin_levels_q[$];
    int      fail_count = 0;

    // one millisecond tick: returns the pin levels after it
    function automatic t_result advance_tick(input logic [WIDTH_W-1:0] raw);
        t_result res;
        int      w;
        int      c;
        int      d;
        int      offset;
        int      idx;
        res.sampled = 1'b0;
        if (since_sample != TICK_MAX) since_sample = since_sample + 1'b1;
        if (since_sample >= period_r) begin
            since_sample = '0;
            res.sampled  = 1'b1;
            if (raw == '0) begin
                stepping = 1'b0;
            end else begin
                w = int'(raw);
                if (w < int'(minw_r)) w = int'(minw_r);
                if (w > int'(maxw_r)) w = int'(maxw_r);
                c = int'(center_r);
                d = int'(dband_r);
                if (w > c - d && w < c + d) begin
                    enable_lvl = 1'b1;
                    stepping   = 1'b0;
                end else begin
                    enable_lvl = 1'b0;
                    stepping   = 1'b1;
                    dir_lvl    = (w < c);
                    offset     = (w < c) ? c - w : w - c;
                    idx        = offset >> DIST_SHIFT;
                    if (idx > int'(TABLE_ENTRIES) - 1) idx = int'(TABLE_ENTRIES) - 1;
                    step_wait = (idx < int'(REG_ENTRIES)) ?
                                delays_r[idx*DELAY_W +: DELAY_W] : '0;
                end
            end
        end
        if (since_step != TICK_MAX) since_step = since_step + 1'b1;
        if (stepping && since_step >= step_wait) begin
            since_step = '0;
            step_lvl   = ~step_lvl;
        end
        res.enable_pin    = enable_lvl;
        res.direction_pin = dir_lvl;
        res.step_pin      = step_lvl;
        return res;
    endfunction

    task automatic log_fault(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            period_r     = SAMPLE_PERIOD_RST;
            center_r     = CENTER_WIDTH_RST;
            dband_r      = DEADBAND_RST;
            minw_r       = MIN_WIDTH_RST;
            maxw_r       = MAX_WIDTH_RST;
            delays_r     = DELAY_TABLE_RST;
            since_sample = '0;
            since_step   = '0;
            stepping     = 1'b0;
            step_wait    = '0;
            enable_lvl   = 1'b0;
            dir_lvl      = 1'b0;
            step_lvl     = 1'b0;
            pin_levels_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SAMPLE_PERIOD: period_r = i_cfg_data[PERIOD_W-1:0];
                    REG_CENTER_WIDTH:  center_r = i_cfg_data[WIDTH_W-1:0];
                    REG_DEADBAND:      dband_r  = i_cfg_data[DBAND_W-1:0];
                    REG_MIN_WIDTH:     minw_r   = i_cfg_data[WIDTH_W-1:0];
                    REG_MAX_WIDTH:     maxw_r   = i_cfg_data[WIDTH_W-1:0];
                    REG_DELAY_TABLE:   delays_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.enable_pin    = i_enable_pin;
                got.direction_pin = i_direction_pin;
                got.step_pin      = i_step_pin;
                got.sampled       = i_sampled;
                if (pin_levels_q.size() == 0) begin
                    log_fault($sformatf("result with nothing pending: en=%b dir=%b step=%b smp=%b",
                        got.enable_pin, got.direction_pin, got.step_pin, got.sampled));
                end else begin
                    want = pin_levels_q.pop_front();
                    if (got.enable_pin !== want.enable_pin ||
                        got.direction_pin !== want.direction_pin ||
                        got.step_pin !== want.step_pin ||
                        got.sampled !== want.sampled)
                        log_fault($sformatf({"pin mismatch: expected en=%b dir=%b step=%b smp=%b",
                            ", got en=%b dir=%b step=%b smp=%b"},
                            want.enable_pin, want.direction_pin, want.step_pin, want.sampled,
                            got.enable_pin, got.direction_pin, got.step_pin, got.sampled));
                end
            end
            if (i_in_valid && !i_in_stall)
                pin_levels_q.push_back(advance_tick(i_pulse_width));
        end
        o_pending    <= pin_levels_q.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> bench/rc_pulse_to_stepper_rate_core_test.sv
`timescale 1ns / 100ps

module rc_pulse_to_stepper_rate_core_test;
    import rcps_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 64;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [WIDTH_W-1:0]   i_pulse_width;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_enable_pin;
    logic                 o_direction_pin;
    logic                 o_step_pin;
    logic                 o_sampled;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TABLE_W-1:0]   i_cfg_data;

    int fail_count;
    int ticks_pending;
    int cycle_count = 0;

    // current center and deadband, used to aim pulse widths at the band edges
    int cfg_center = CENTER_WIDTH_RST;
    int cfg_dband  = DEADBAND_RST;

    // idle control for the request and result sides; quiet_tail is shared by both
    logic quiet_tail = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    int   calm_left  = 0;

    // directed widths, sampled on every tick under the reset clamps and table:
    // no signal, band center and both band edges, clamp extremes,
    // one width per table index up to saturation, alternating bit patterns
    int directed_widths[$] = '{
        0, 1500, 1451, 1450, 1549, 1550, 4095, 1, 0, 0,
        1000, 2000, 999, 2001, 1564, 1563, 1628, 1692, 1756, 1820,
        1884, 1948, 2047, 2730, 1365
    };

    rc_pulse_to_stepper_rate_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pulse_width   (i_pulse_width),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_enable_pin    (o_enable_pin),
        .o_direction_pin (o_direction_pin),
        .o_step_pin      (o_step_pin),
        .o_sampled       (o_sampled),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // watches all three channels, predicts the pin levels and compares
    rc_pulse_to_stepper_rate_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES_DEF),
        .DIST_SHIFT    (DIST_SHIFT_DEF)
    ) pin_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pulse_width   (i_pulse_width),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_enable_pin    (o_enable_pin),
        .i_direction_pin (o_direction_pin),
        .i_step_pin      (o_step_pin),
        .i_sampled       (o_sampled),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (ticks_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a request or a result never gets through
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side stall: one long hold-off on request, random short bursts,
    // calm stretches now and then, nothing at all in the tail of the run
    initial begin : result_stall_drive
        int calm;
        calm = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // keep the results blocked so the core fills and stalls its input
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (calm > 0) begin
                calm--;
            end else if ($urandom_range(0, 29) == 0) begin
                calm = $urandom_range(10, 40);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // one tick request, with a random gap ahead of it; valid stays high
    // from one request to the next when there is no gap
    task automatic send_tick(input logic [WIDTH_W-1:0] width);
        if (calm_left > 0) begin
            calm_left--;
        end else if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
        end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pulse_width <= width;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain_ticks();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ticks_pending != 0);
    endtask

    // one register write request; valid is lowered by the caller
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full register set, written only while the core is idle
    task automatic write_config(input int period, input int center, input int dband,
                                input int minw, input int maxw,
                                input logic [TABLE_W-1:0] delays);
        cfg_center = center;
        cfg_dband  = dband;
        cfg_write(REG_SAMPLE_PERIOD, TABLE_W'(period));
        cfg_write(REG_CENTER_WIDTH,  TABLE_W'(center));
        cfg_write(REG_DEADBAND,      TABLE_W'(dband));
        cfg_write(REG_MIN_WIDTH,     TABLE_W'(minw));
        cfg_write(REG_MAX_WIDTH,     TABLE_W'(maxw));
        cfg_write(REG_DELAY_TABLE,   delays);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly widths around the center, some right at the band edges,
    // some anywhere in the field and some with no signal
    function automatic logic [WIDTH_W-1:0] pick_width();
        int r;
        int w;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 25) return WIDTH_W'($urandom_range(1, 4095));
        if (r < 35)
            w = cfg_center + (($urandom_range(0, 1) == 0) ? -cfg_dband : cfg_dband)
                + $urandom_range(0, 2) - 1;
        else
            w = cfg_center + $urandom_range(0, 1200) - 600;
        if (w < 1) w = 1;
        if (w > 4095) w = 4095;
        return WIDTH_W'(w);
    endfunction

    task automatic run_ticks(input int count);
        repeat (count) send_tick(pick_width());
        drain_ticks();
    endtask

    initial begin : stimulus
        int period;
        int center;
        int dband;
        int minw;
        int maxw;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_pulse_width <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_SAMPLE_PERIOD;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: one sample per hundred ticks
        run_ticks(150);

        // directed widths, sampled on every tick
        write_config(1, CENTER_WIDTH_RST, DEADBAND_RST, MIN_WIDTH_RST, MAX_WIDTH_RST,
                     DELAY_TABLE_RST);
        foreach (directed_widths[k]) send_tick(WIDTH_W'(directed_widths[k]));
        drain_ticks();

        // period zero, everything clamped to zero, empty band, zero delays
        write_config(0, 0, 0, 0, 0, '0);
        run_ticks(20);

        // crossed clamps, widest band at the top center, longest delays
        write_config(1, 4095, 1023, 3000, 100, '1);
        run_ticks(20);

        // longest period: no sample in this phase, stepping carries on
        write_config(65535, 2048, 0, 0, 4095, 32'h0123_4567);
        run_ticks(25);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 15))
                0:       period = 0;
                1:       period = 1;
                14:      period = 100;
                15:      period = 65535;
                default: period = $urandom_range(2, 8);
            endcase
            center = ($urandom_range(0, 1) == 0) ? $urandom_range(800, 2200)
                                                 : $urandom_range(0, 4095);
            dband  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 200)
                                                : $urandom_range(0, 1023);
            if ($urandom_range(0, 9) < 6) begin
                minw = center - $urandom_range(0, 700);
                maxw = center + $urandom_range(0, 700);
                if (minw < 0) minw = 0;
                if (maxw > 4095) maxw = 4095;
            end else begin
                minw = $urandom_range(0, 4095);
                maxw = $urandom_range(0, 4095);
            end
            write_config(period, center, dband, minw, maxw, $urandom());
            // long receiver hold-off in one phase, no idling in the last one
            if (ph == 2) hold_req = 1'b1;
            if (ph == RAND_PHASES - 1) quiet_tail = 1'b1;
            run_ticks(PHASE_TICKS);
        end

        // let any stray result show up before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/rcps_pkg.sv
sv/rc_pulse_to_stepper_rate_core.sv
bench/rc_pulse_to_stepper_rate_checker.sv
bench/rc_pulse_to_stepper_rate_core_test.sv
